[rtl/position_window_swipe_classifier_macros.svh]
// Assertion macros for the checker of the swipe classifier.
// Each macro samples on the rising edge of clk and stays quiet while rst_n is low.
`ifndef POSITION_WINDOW_SWIPE_CLASSIFIER_MACROS_SVH
`define POSITION_WINDOW_SWIPE_CLASSIFIER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PWSC_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pwsc assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define PWSC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pwsc assertion failed");

`endif

[rtl/pwsc_pkg.sv]
package pwsc_pkg;

    localparam int MAX_WINDOW = 16;
    localparam int IDX_W      = $clog2(MAX_WINDOW);
    localparam int LEN_W      = IDX_W + 1;
    localparam int CNT_W      = IDX_W;
    localparam int SAMPLE_W   = 3;
    localparam int POS_W      = 4;
    localparam int RUN_W      = 4;
    localparam int TOL_W      = 10;
    localparam int CMD_W      = 2;
    localparam int SUM_W      = SAMPLE_W + CNT_W;
    localparam int TOLC_W     = TOL_W + CNT_W;
    localparam int D_W        = SUM_W + 2;
    localparam int Q_SHIFT    = 8;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = TOL_W;

    localparam logic [RUN_W-1:0] RUN_MAX   = RUN_W'(15);
    localparam logic [RUN_W-1:0] RUN_LIMIT = RUN_W'(3);

    localparam logic [LEN_W-1:0] LEN_MIN   = LEN_W'(2);
    localparam logic [LEN_W-1:0] LEN_MAX   = LEN_W'(MAX_WINDOW);
    localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(8);
    localparam logic [TOL_W-1:0] TOL_RESET = TOL_W'(64);

    // Register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LENGTH = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_TOLERANCE     = 1'b1;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_NONE  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_LEFT  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_RIGHT = 2'd2;

    // Half-mean targets
    localparam logic [1:0] TGT_ZERO = 2'd0;
    localparam logic [1:0] TGT_ONE  = 2'd1;
    localparam logic [1:0] TGT_TWO  = 2'd2;

    // Datapath operations
    localparam int OP_W = 3;
    localparam logic [OP_W-1:0] OP_ACCEPT = 3'd0;
    localparam logic [OP_W-1:0] OP_INIT   = 3'd1;
    localparam logic [OP_W-1:0] OP_SCAN   = 3'd2;
    localparam logic [OP_W-1:0] OP_TAIL   = 3'd3;
    localparam logic [OP_W-1:0] OP_EVAL   = 3'd4;

    // Jump conditions
    localparam int COND_W = 3;
    localparam logic [COND_W-1:0] COND_ALWAYS   = 3'd0;
    localparam logic [COND_W-1:0] COND_IN_ACC   = 3'd1;
    localparam logic [COND_W-1:0] COND_SKIP     = 3'd2;
    localparam logic [COND_W-1:0] COND_LAST     = 3'd3;
    localparam logic [COND_W-1:0] COND_OUT_FREE = 3'd4;

    // Program steps
    localparam int STEP_W = 3;
    localparam logic [STEP_W-1:0] STEP_IDLE = 3'd0;
    localparam logic [STEP_W-1:0] STEP_INIT = 3'd1;
    localparam logic [STEP_W-1:0] STEP_SCAN = 3'd2;
    localparam logic [STEP_W-1:0] STEP_TAIL = 3'd3;
    localparam logic [STEP_W-1:0] STEP_EVAL = 3'd4;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [COND_W-1:0] cond;
        logic [STEP_W-1:0] nxt_true;
        logic [STEP_W-1:0] nxt_false;
    } ucode_t;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            in_ready;
    } ctrl_t;

    typedef struct packed {
        logic in_acc;
        logic skip;
        logic last;
        logic out_free;
    } stat_t;

    // |s - t*c| * 256 < tol * c, with tc = tol * c already formed
    function automatic logic near_f(
        input logic [SUM_W-1:0]  s,
        input logic [CNT_W-1:0]  c,
        input logic [1:0]        t,
        input logic [TOLC_W-1:0] tc
    );
        logic [D_W-1:0]         tcnt;
        logic signed [D_W-1:0]  d;
        logic [D_W-1:0]         a;
        logic [D_W+Q_SHIFT-1:0] lhs;
        logic [D_W+Q_SHIFT-1:0] rhs;
        tcnt = D_W'(t) * D_W'(c);
        d    = $signed({2'b00, s}) - $signed(tcnt);
        a    = d[D_W-1] ? D_W'(-d) : D_W'(d);
        lhs  = {a, {Q_SHIFT{1'b0}}};
        rhs  = {{(D_W + Q_SHIFT - TOLC_W){1'b0}}, tc};
        return lhs < rhs;
    endfunction

endpackage

[rtl/pwsc_sequencer.sv]
module pwsc_sequencer (
    input  logic             clk,
    input  logic             rst_n,
    input  pwsc_pkg::stat_t  stat,
    output pwsc_pkg::ctrl_t  ctrl
);

    logic [pwsc_pkg::STEP_W-1:0] step_reg;
    logic [pwsc_pkg::STEP_W-1:0] step_next;
    pwsc_pkg::ucode_t            word;
    logic                        cond_true;

    // Control store: one word per step
    function automatic pwsc_pkg::ucode_t ucode_rom(input logic [pwsc_pkg::STEP_W-1:0] s);
        pwsc_pkg::ucode_t w;
        unique case (s)
            pwsc_pkg::STEP_IDLE: w = '{pwsc_pkg::OP_ACCEPT, pwsc_pkg::COND_IN_ACC,
                                       pwsc_pkg::STEP_INIT, pwsc_pkg::STEP_IDLE};
            pwsc_pkg::STEP_INIT: w = '{pwsc_pkg::OP_INIT, pwsc_pkg::COND_SKIP,
                                       pwsc_pkg::STEP_EVAL, pwsc_pkg::STEP_SCAN};
            pwsc_pkg::STEP_SCAN: w = '{pwsc_pkg::OP_SCAN, pwsc_pkg::COND_LAST,
                                       pwsc_pkg::STEP_TAIL, pwsc_pkg::STEP_SCAN};
            pwsc_pkg::STEP_TAIL: w = '{pwsc_pkg::OP_TAIL, pwsc_pkg::COND_ALWAYS,
                                       pwsc_pkg::STEP_EVAL, pwsc_pkg::STEP_EVAL};
            pwsc_pkg::STEP_EVAL: w = '{pwsc_pkg::OP_EVAL, pwsc_pkg::COND_OUT_FREE,
                                       pwsc_pkg::STEP_IDLE, pwsc_pkg::STEP_EVAL};
            default:             w = '{pwsc_pkg::OP_ACCEPT, pwsc_pkg::COND_ALWAYS,
                                       pwsc_pkg::STEP_IDLE, pwsc_pkg::STEP_IDLE};
        endcase
        return w;
    endfunction

    assign word = ucode_rom(step_reg);

    always_comb
    begin
        unique case (word.cond)
            pwsc_pkg::COND_ALWAYS:   cond_true = 1'b1;
            pwsc_pkg::COND_IN_ACC:   cond_true = stat.in_acc;
            pwsc_pkg::COND_SKIP:     cond_true = stat.skip;
            pwsc_pkg::COND_LAST:     cond_true = stat.last;
            pwsc_pkg::COND_OUT_FREE: cond_true = stat.out_free;
            default:                 cond_true = 1'b1;
        endcase
    end

    assign step_next     = cond_true ? word.nxt_true : word.nxt_false;
    assign ctrl.op       = word.op;
    assign ctrl.in_ready = (word.op == pwsc_pkg::OP_ACCEPT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= pwsc_pkg::STEP_IDLE;
        end
        else
        begin
            step_reg <= step_next;
        end
    end

endmodule

[rtl/pwsc_datapath.sv]
module pwsc_datapath (
    input  logic                            clk,
    input  logic                            rst_n,
    input  pwsc_pkg::ctrl_t                 ctrl,
    output pwsc_pkg::stat_t                 stat,
    input  logic                            in_valid,
    input  logic signed [pwsc_pkg::POS_W-1:0] position,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [pwsc_pkg::CMD_W-1:0]      command,
    input  logic                            cfg_we,
    input  logic [pwsc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [pwsc_pkg::CFG_DATA_W-1:0] cfg_data
);

    // Newest sample at entry 0
    logic [pwsc_pkg::SAMPLE_W-1:0] win_reg [pwsc_pkg::MAX_WINDOW];

    logic [pwsc_pkg::LEN_W-1:0]    len_reg;
    logic [pwsc_pkg::TOL_W-1:0]    tol_reg;
    logic [pwsc_pkg::LEN_W-1:0]    fill_reg;
    logic [pwsc_pkg::LEN_W-1:0]    fill_next;
    logic [pwsc_pkg::RUN_W-1:0]    run_reg;
    logic [pwsc_pkg::RUN_W-1:0]    run_next;
    logic [pwsc_pkg::IDX_W-1:0]    j_reg;
    logic                          out_valid_reg;
    logic                          out_valid_next;
    logic [pwsc_pkg::CMD_W-1:0]    cmd_reg;

    logic [pwsc_pkg::CNT_W-1:0]    c0_reg;
    logic [pwsc_pkg::CNT_W-1:0]    c1_reg;
    logic [pwsc_pkg::TOLC_W-1:0]   tolc0_reg;
    logic [pwsc_pkg::TOLC_W-1:0]   tolc1_reg;
    logic [pwsc_pkg::SUM_W-1:0]    sum0_reg;
    logic [pwsc_pkg::SUM_W-1:0]    sum1_reg;
    logic [pwsc_pkg::SAMPLE_W-1:0] p_reg;
    logic [pwsc_pkg::SAMPLE_W-1:0] c_reg;

    logic                          in_acc;
    logic                          pos_neg;
    logic [pwsc_pkg::LEN_W-1:0]    len_wr;
    logic [pwsc_pkg::LEN_W-1:0]    n_m1;
    logic [pwsc_pkg::IDX_W-1:0]    rd_idx;
    logic [pwsc_pkg::SAMPLE_W-1:0] rd_val;
    logic [pwsc_pkg::SAMPLE_W-1:0] fix_val;
    logic [pwsc_pkg::CNT_W-1:0]    half;
    logic [pwsc_pkg::LEN_W-1:0]    rest;
    logic                          in_old_half;
    logic                          go_right;
    logic                          go_left;
    logic [pwsc_pkg::CMD_W-1:0]    cmd_new;

    assign in_acc  = in_valid && ctrl.in_ready;
    assign pos_neg = position[pwsc_pkg::POS_W-1];

    // Clamp a written window length into 2..MAX_WINDOW
    always_comb
    begin
        if (cfg_data[pwsc_pkg::LEN_W-1:0] < pwsc_pkg::LEN_MIN)
            len_wr = pwsc_pkg::LEN_MIN;
        else if (cfg_data[pwsc_pkg::LEN_W-1:0] > pwsc_pkg::LEN_MAX)
            len_wr = pwsc_pkg::LEN_MAX;
        else
            len_wr = cfg_data[pwsc_pkg::LEN_W-1:0];
    end

    assign n_m1   = fill_reg - pwsc_pkg::LEN_W'(1);
    assign rd_idx = pwsc_pkg::IDX_W'(n_m1 - pwsc_pkg::LEN_W'(j_reg));
    assign rd_val = win_reg[rd_idx];

    // A middle sample whose neighbours agree takes their value
    always_comb
    begin
        if (j_reg == pwsc_pkg::IDX_W'(1))
            fix_val = c_reg;
        else if (p_reg == rd_val)
            fix_val = p_reg;
        else
            fix_val = c_reg;
    end

    assign half        = fill_reg[pwsc_pkg::LEN_W-1:1];
    assign rest        = fill_reg - pwsc_pkg::LEN_W'(half);
    assign in_old_half = pwsc_pkg::LEN_W'(j_reg) <= pwsc_pkg::LEN_W'(c0_reg);

    assign go_right = pwsc_pkg::near_f(sum1_reg, c1_reg, pwsc_pkg::TGT_TWO, tolc1_reg)
                   && (pwsc_pkg::near_f(sum0_reg, c0_reg, pwsc_pkg::TGT_ZERO, tolc0_reg)
                    || pwsc_pkg::near_f(sum0_reg, c0_reg, pwsc_pkg::TGT_ONE, tolc0_reg));
    assign go_left  = pwsc_pkg::near_f(sum1_reg, c1_reg, pwsc_pkg::TGT_ZERO, tolc1_reg)
                   && (pwsc_pkg::near_f(sum0_reg, c0_reg, pwsc_pkg::TGT_ONE, tolc0_reg)
                    || pwsc_pkg::near_f(sum0_reg, c0_reg, pwsc_pkg::TGT_TWO, tolc0_reg));

    always_comb
    begin
        if (stat.skip)
            cmd_new = pwsc_pkg::CMD_NONE;
        else if (go_right)
            cmd_new = pwsc_pkg::CMD_RIGHT;
        else if (go_left)
            cmd_new = pwsc_pkg::CMD_LEFT;
        else
            cmd_new = pwsc_pkg::CMD_NONE;
    end

    assign stat.in_acc   = in_acc;
    assign stat.skip     = (fill_reg < pwsc_pkg::LEN_MIN) || (run_reg > pwsc_pkg::RUN_LIMIT);
    assign stat.last     = (pwsc_pkg::LEN_W'(j_reg) == n_m1);
    assign stat.out_free = !out_valid_reg || out_ready;

    // Sample and run counters: item entry, and trimming on a length write
    always_comb
    begin
        fill_next = fill_reg;
        run_next  = run_reg;
        if (cfg_we && (cfg_index == pwsc_pkg::REG_WINDOW_LENGTH))
        begin
            if (fill_reg > len_wr)
                fill_next = len_wr;
        end
        else if (in_acc)
        begin
            if (pos_neg)
            begin
                if (run_reg != pwsc_pkg::RUN_MAX)
                    run_next = run_reg + pwsc_pkg::RUN_W'(1);
            end
            else
            begin
                run_next  = '0;
                fill_next = (fill_reg < len_reg) ? fill_reg + pwsc_pkg::LEN_W'(1) : len_reg;
            end
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if ((ctrl.op == pwsc_pkg::OP_EVAL) && stat.out_free)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg       <= pwsc_pkg::LEN_RESET;
            tol_reg       <= pwsc_pkg::TOL_RESET;
            fill_reg      <= '0;
            run_reg       <= '0;
            j_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            fill_reg      <= fill_next;
            run_reg       <= run_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    pwsc_pkg::REG_WINDOW_LENGTH: len_reg <= len_wr;
                    pwsc_pkg::REG_TOLERANCE:     tol_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (ctrl.op == pwsc_pkg::OP_INIT)
                j_reg <= '0;
            else if (ctrl.op == pwsc_pkg::OP_SCAN)
                j_reg <= j_reg + pwsc_pkg::IDX_W'(1);
        end
    end

    // Payload: window, half sums, scan pipeline, result
    always_ff @(posedge clk)
    begin
        if (in_acc && !pos_neg)
        begin
            for (int k = pwsc_pkg::MAX_WINDOW - 1; k > 0; k--)
                win_reg[k] <= win_reg[k-1];
            win_reg[0] <= position[pwsc_pkg::SAMPLE_W-1:0];
        end
        case (ctrl.op)
            pwsc_pkg::OP_INIT:
            begin
                c0_reg    <= half;
                c1_reg    <= pwsc_pkg::CNT_W'(rest);
                tolc0_reg <= pwsc_pkg::TOLC_W'(tol_reg) * pwsc_pkg::TOLC_W'(half);
                tolc1_reg <= pwsc_pkg::TOLC_W'(tol_reg) * pwsc_pkg::TOLC_W'(rest);
                sum0_reg  <= '0;
                sum1_reg  <= '0;
            end
            pwsc_pkg::OP_SCAN:
            begin
                // Hold the previous corrected sample and the current raw one
                c_reg <= rd_val;
                if (j_reg != '0)
                begin
                    p_reg <= fix_val;
                    if (in_old_half)
                        sum0_reg <= sum0_reg + pwsc_pkg::SUM_W'(fix_val);
                    else
                        sum1_reg <= sum1_reg + pwsc_pkg::SUM_W'(fix_val);
                end
            end
            pwsc_pkg::OP_TAIL:
            begin
                sum1_reg <= sum1_reg + pwsc_pkg::SUM_W'(c_reg);
            end
            pwsc_pkg::OP_EVAL:
            begin
                if (stat.out_free)
                    cmd_reg <= cmd_new;
            end
            default: ;
        endcase
    end

    assign out_valid = out_valid_reg;
    assign command   = cmd_reg;

endmodule

[rtl/position_window_swipe_classifier.sv]
// Channel   | Handshake           | Payload
// ----------+---------------------+---------------------------------------
// input     | in_valid, in_ready  | position (4 b, signed, negative = none)
// output    | out_valid, out_ready| command (2 b: 0 none, 1 left, 2 right)
// config    | cfg_we              | cfg_index (0 length, 1 tolerance), cfg_data
//
// An item passes through the accept, init, scan, tail and eval steps; the window
// scan reads one sample per cycle, and scan and tail are skipped when fewer than two
// samples are held or the invalid run is above three.
// Reset (rst_n low, asynchronous) empties the window, clears the invalid run and
// loads length 8 and tolerance 64; no clearing pass follows.
// The result sits in an output register: the next item is taken while it waits,
// and only the following result stalls until out_ready.
module position_window_swipe_classifier (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic signed [pwsc_pkg::POS_W-1:0] position,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [pwsc_pkg::CMD_W-1:0]        command,
    input  logic                              cfg_we,
    input  logic [pwsc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [pwsc_pkg::CFG_DATA_W-1:0]   cfg_data
);

    pwsc_pkg::ctrl_t ctrl;
    pwsc_pkg::stat_t stat;

    pwsc_sequencer u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .stat  (stat),
        .ctrl  (ctrl)
    );

    pwsc_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (ctrl),
        .stat      (stat),
        .in_valid  (in_valid),
        .position  (position),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .command   (command),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    assign in_ready = ctrl.in_ready;

endmodule

[rtl/pwsc_checker.sv]
`include "position_window_swipe_classifier_macros.svh"

module pwsc_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       in_valid,
    input logic                       in_ready,
    input logic                       out_valid,
    input logic                       out_ready,
    input logic [pwsc_pkg::CMD_W-1:0] command
);

    // A waiting result holds its beat
    `PWSC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(command))

    // Only defined command codes leave the block
    `PWSC_ASSERT_SAME(a_cmd_code, out_valid, (command == pwsc_pkg::CMD_NONE) || (command == pwsc_pkg::CMD_LEFT) || (command == pwsc_pkg::CMD_RIGHT))

    // An accepted item takes the block busy
    `PWSC_ASSERT_NEXT(a_busy_after_in, in_valid && in_ready, !in_ready)

    // A new result is launched only from a busy cycle
    `PWSC_ASSERT_SAME(a_result_from_work, $rose(out_valid), !$past(in_ready))

endmodule

bind position_window_swipe_classifier pwsc_checker u_pwsc_checker (.*);

[dv/position_window_swipe_classifier_test.sv]
module position_window_swipe_classifier_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int PHASES      = 10;
    localparam int PHASE_ITEMS = 150;
    localparam int HOLD_CYCLES = 400;
    localparam int STALL_LIMIT = 4000;
    localparam int DRAIN_WAIT  = 40;

    class swipe_checker;
        logic [pwsc_pkg::SAMPLE_W-1:0] samples [pwsc_pkg::MAX_WINDOW];   // newest first
        int                            held;
        int                            miss_run;
        int                            len_reg;
        int                            tol_reg;
        logic [pwsc_pkg::CMD_W-1:0]    owed_commands [$];
        int                            errors;

        function new();
            held     = 0;
            miss_run = 0;
            len_reg  = int'(pwsc_pkg::LEN_RESET);
            tol_reg  = int'(pwsc_pkg::TOL_RESET);
            errors   = 0;
        endfunction

        function int span();
            if (len_reg < int'(pwsc_pkg::LEN_MIN))
                return int'(pwsc_pkg::LEN_MIN);
            if (len_reg > pwsc_pkg::MAX_WINDOW)
                return pwsc_pkg::MAX_WINDOW;
            return len_reg;
        endfunction

        function int pending();
            return owed_commands.size();
        endfunction

        function void write_reg(logic [pwsc_pkg::CFG_IDX_W-1:0] idx,
                                logic [pwsc_pkg::CFG_DATA_W-1:0] data);
            if (idx == pwsc_pkg::REG_WINDOW_LENGTH)
            begin
                len_reg = int'(data[4:0]);
                // drop the oldest samples beyond a shorter window at once
                if (held > span())
                    held = span();
            end
            else
                tol_reg = int'(data);
        endfunction

        function bit near(int s, int c, int t);
            int d;
            d = s * 256 - t * 256 * c;
            if (d < 0)
                d = -d;
            return d < tol_reg * c;
        endfunction

        function logic [pwsc_pkg::CMD_W-1:0] classify_window();
            logic [pwsc_pkg::SAMPLE_W-1:0] seq [pwsc_pkg::MAX_WINDOW];
            int                            n;
            int                            h;
            int                            k;
            int                            sum_old;
            int                            sum_new;
            n       = held;
            sum_old = 0;
            sum_new = 0;
            if (n < 2 || miss_run > int'(pwsc_pkg::RUN_LIMIT))
                return pwsc_pkg::CMD_NONE;
            for (k = 0; k < n; k++)
                seq[k] = samples[n - 1 - k];
            // smooth single-sample glitches, oldest first, on the corrected values
            for (k = 1; k + 1 < n; k++)
                if (seq[k - 1] == seq[k + 1] && seq[k] != seq[k - 1])
                    seq[k] = seq[k - 1];
            h = n / 2;
            for (k = 0; k < n; k++)
                if (k < h)
                    sum_old += int'(seq[k]);
                else
                    sum_new += int'(seq[k]);
            if (near(sum_new, n - h, int'(pwsc_pkg::TGT_TWO)) &&
                (near(sum_old, h, int'(pwsc_pkg::TGT_ZERO)) ||
                 near(sum_old, h, int'(pwsc_pkg::TGT_ONE))))
                return pwsc_pkg::CMD_RIGHT;
            if (near(sum_new, n - h, int'(pwsc_pkg::TGT_ZERO)) &&
                (near(sum_old, h, int'(pwsc_pkg::TGT_ONE)) ||
                 near(sum_old, h, int'(pwsc_pkg::TGT_TWO))))
                return pwsc_pkg::CMD_LEFT;
            return pwsc_pkg::CMD_NONE;
        endfunction

        function void note_position(logic signed [pwsc_pkg::POS_W-1:0] p);
            int k;
            if (p[pwsc_pkg::POS_W-1])
            begin
                if (miss_run < int'(pwsc_pkg::RUN_MAX))
                    miss_run++;
            end
            else
            begin
                miss_run = 0;
                for (k = pwsc_pkg::MAX_WINDOW - 1; k > 0; k--)
                    samples[k] = samples[k - 1];
                samples[0] = p[pwsc_pkg::SAMPLE_W-1:0];
                if (held < span())
                    held++;
            end
            owed_commands.insert(owed_commands.size(), classify_window());
        endfunction

        function void check_command(logic [pwsc_pkg::CMD_W-1:0] got);
            logic [pwsc_pkg::CMD_W-1:0] want;
            if (owed_commands.size() == 0)
            begin
                errors++;
                $display("%0t: command expected none, actual %0d", $time, got);
                return;
            end
            want = owed_commands[0];
            owed_commands.delete(0);
            if (got !== want)
            begin
                errors++;
                $display("%0t: command expected %0d, actual %0d", $time, want, got);
            end
        endfunction
    endclass

    logic                                clk       = 1'b0;
    logic                                rst_n     = 1'b0;
    logic                                in_valid  = 1'b0;
    logic                                in_ready;
    logic signed [pwsc_pkg::POS_W-1:0]   position  = '0;
    logic                                out_valid;
    logic                                out_ready = 1'b0;
    logic [pwsc_pkg::CMD_W-1:0]          command;
    logic                                cfg_we    = 1'b0;
    logic [pwsc_pkg::CFG_IDX_W-1:0]      cfg_index = '0;
    logic [pwsc_pkg::CFG_DATA_W-1:0]     cfg_data  = '0;

    swipe_checker board;
    bit           steady     = 1'b0;
    bit           squeeze_req = 1'b0;

    position_window_swipe_classifier dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .position  (position),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .command   (command),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    task automatic send_position(input logic signed [pwsc_pkg::POS_W-1:0] p);
        while (!steady && $urandom_range(99) < 27)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        position <= p;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        board.note_position(p);
    endtask

    function automatic logic signed [pwsc_pkg::POS_W-1:0] any_miss();
        return pwsc_pkg::POS_W'($urandom_range(8, 15));
    endfunction

    // one gesture across roughly a full window, with jitter, glitches and dropouts
    task automatic send_swipe(output int sent);
        int n;
        int k;
        int r;
        int older;
        int newer;
        int base;
        bit rightward;
        logic signed [pwsc_pkg::POS_W-1:0] p;
        n         = board.span() + $urandom_range(0, 3);
        rightward = 1'($urandom_range(1));
        older     = rightward ? $urandom_range(0, 1) : $urandom_range(1, 2);
        newer     = rightward ? 2 : 0;
        for (k = 0; k < n; k++)
        begin
            base = (k < n / 2) ? older : newer;
            r    = $urandom_range(99);
            if (r < 6)
                p = pwsc_pkg::POS_W'($urandom_range(7));
            else if (r < 10)
                p = any_miss();
            else if (r < 16)
                p = pwsc_pkg::POS_W'((base > 0 && $urandom_range(1)) ? base - 1 : base + 1);
            else
                p = pwsc_pkg::POS_W'(base);
            send_position(p);
        end
        sent = n;
    endtask

    task automatic send_random_run(output int sent);
        int r;
        int n;
        int k;
        r = $urandom_range(99);
        if (r < 65)
            send_swipe(sent);
        else if (r < 85)
        begin
            n = $urandom_range(1, 8);
            for (k = 0; k < n; k++)
                send_position(pwsc_pkg::POS_W'($urandom_range(15)));
            sent = n;
        end
        else
        begin
            // dropout run, long enough at times to saturate the counter
            n = $urandom_range(1, 18);
            for (k = 0; k < n; k++)
                send_position(any_miss());
            sent = n;
        end
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        while (board.pending() != 0)
            @(posedge clk);
    endtask

    task automatic program_regs(input int len, input int tol);
        logic [pwsc_pkg::CFG_DATA_W-1:0] len_data;
        logic [pwsc_pkg::CFG_DATA_W-1:0] tol_data;
        len_data  = pwsc_pkg::CFG_DATA_W'({5'($urandom_range(31)), 5'(len)});
        tol_data  = pwsc_pkg::CFG_DATA_W'(tol);
        cfg_we    <= 1'b1;
        cfg_index <= pwsc_pkg::REG_WINDOW_LENGTH;
        cfg_data  <= len_data;
        @(posedge clk);
        board.write_reg(pwsc_pkg::REG_WINDOW_LENGTH, len_data);
        cfg_index <= pwsc_pkg::REG_TOLERANCE;
        cfg_data  <= tol_data;
        @(posedge clk);
        board.write_reg(pwsc_pkg::REG_TOLERANCE, tol_data);
        cfg_we    <= 1'b0;
    endtask

    initial
    begin : drain
        @(posedge clk);
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && out_ready)
                board.check_command(command);
            if (squeeze_req)
            begin
                // hold off the sink so the block backs up into its input
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                squeeze_req = 1'b0;
            end
            else
                out_ready <= steady || ($urandom_range(99) >= 27);
        end
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        forever
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet = 0;
            else
                quiet++;
            if (quiet >= STALL_LIMIT)
            begin
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    initial
    begin : stimulus
        logic signed [pwsc_pkg::POS_W-1:0] opening [25];
        int len_set [PHASES];
        int tol_set [PHASES];
        int phase;
        int count;
        int sent;
        int i;
        board   = new();
        // first beat with too few samples, every dropout code, then gestures
        opening = '{0, -1, -2, -3, -4, -5, -6, -7, -8,
                    0, 0, 7, 0, 2, 2, 2, 2,
                    2, 2, 2, 2, 0, 0, 0, 0};
        len_set = '{2, 16, 0, 31, 1, 17, 5, 8, 0, 0};
        tol_set = '{0, 1023, 64, 128, 200, 90, 256, 64, 0, 0};
        len_set[8] = $urandom_range(31);
        tol_set[8] = $urandom_range(1023);
        len_set[9] = $urandom_range(2, 16);
        tol_set[9] = $urandom_range(20, 400);
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        for (i = 0; i < 25; i++)
            send_position(opening[i]);
        for (phase = 0; phase < PHASES; phase++)
        begin
            settle();
            program_regs(len_set[phase], tol_set[phase]);
            steady = (phase == 3);
            if (phase == 1)
                squeeze_req = 1'b1;
            count = 0;
            while (count < PHASE_ITEMS)
            begin
                send_random_run(sent);
                count += sent;
            end
        end
        in_valid <= 1'b0;
        while (board.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
        if (board.errors == 0 && board.pending() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
